// ===== sv/ptsd_pkg.sv =====
// Package for the point to segment distance block: widths, item types and helpers.
package ptsd_pkg;

	localparam int CW       = 16;          // coordinate width
	localparam int OUT_BITS = 25;          // distance result width
	localparam int DW       = CW + 1;      // coordinate difference, signed
	localparam int PW       = 2 * DW;      // product of two differences, signed
	localparam int SW       = PW + 1;      // sum of two products, signed
	localparam int LW       = 2 * CW + 1;  // squared length, unsigned
	localparam int CMAG     = 2 * CW + 1;  // magnitude of the cross product
	localparam int SQW      = 2 * OUT_BITS;

	typedef struct packed {
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] end_x;
		logic signed [CW-1:0] end_y;
		logic                 segment_mode;
	} ptsd_in_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] dist_res;
		logic                degenerate;
	} ptsd_out_t;

	// sideband that rides along the pipeline from front-end stage 4 onward
	typedef struct packed {
		logic valid;
		logic degen;
	} ptsd_ctl_t;

	function automatic logic signed [DW-1:0] sdiff(logic signed [CW-1:0] a,
		logic signed [CW-1:0] b);
		logic [DW-1:0] r;
		r = {a[CW-1], a} - {b[CW-1], b};
		return $signed(r);
	endfunction

endpackage

// ===== sv/point_to_segment_distance.sv =====
// Top level of the point to line / segment distance pipeline.
//
// Input channel in_valid/in_ready/in_item carries a query point, the two line
// ends and the segment_mode flag. Output channel out_valid/out_ready/out_item
// carries dist_res (distance, FRAC_BITS fraction bits, truncated, saturated
// to 25 bits) and the degenerate flag for coincident line ends.
// Throughput: one item per cycle while the output is not stalled. The front
// end is followed by the divider (one quotient bit a stage) and the square
// root (one root bit a stage).
// The whole pipeline advances together; when out_valid is high and out_ready
// low, every stage holds and in_ready drops, so no item is lost or repeated.
// The last square-root stage is the output register.
// Reset (arst_n low) clears all valid and degenerate bits; data registers are not reset.
module point_to_segment_distance import ptsd_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ptsd_in_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output ptsd_out_t out_item
);

	localparam int NW = 2 * CMAG + 2 * FRAC_BITS;
	localparam int QW = 2 * CW + 1 + 2 * FRAC_BITS;

	logic                adv;
	ptsd_ctl_t           fr_ctl, dv_ctl, sq_ctl;
	logic [NW-1:0]       num;
	logic [LW-1:0]       den;
	logic [QW-1:0]       quo;
	logic [OUT_BITS-1:0] root;

	// global advance: stall only while a finished item waits at the output
	assign adv      = !sq_ctl.valid || out_ready;
	assign in_ready = adv;

	ptsd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(in_valid),
		.in_item (in_item),
		.ctl     (fr_ctl),
		.num     (num),
		.den     (den)
	);

	ptsd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_ctl (fr_ctl),
		.num    (num),
		.den    (den),
		.out_ctl(dv_ctl),
		.quo    (quo)
	);

	ptsd_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_ctl (dv_ctl),
		.val    (quo),
		.out_ctl(sq_ctl),
		.root   (root)
	);

	assign out_valid           = sq_ctl.valid;
	assign out_item.dist_res   = root;
	assign out_item.degenerate = sq_ctl.degen;

endmodule

// ===== sv/ptsd_front.sv =====
// Front end: differences, products, dot/cross/length sums, case select, numerator.
module ptsd_front import ptsd_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  ptsd_in_t                      in_item,
	output ptsd_ctl_t                     ctl,
	output logic [2*CMAG+2*FRAC_BITS-1:0] num,
	output logic [LW-1:0]                 den
);

	localparam int NW  = 2 * CMAG + 2 * FRAC_BITS;
	localparam int H   = (CMAG + 1) / 2;
	localparam int HIW = CMAG - H;

	// stage 1: differences
	logic signed [DW-1:0] vx_s1, vy_s1, dx_s1, dy_s1, qx_s1, qy_s1;
	logic                 seg_s1, valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s1  <= sdiff(in_item.end_x, in_item.start_x);
			vy_s1  <= sdiff(in_item.end_y, in_item.start_y);
			dx_s1  <= sdiff(in_item.point_x, in_item.start_x);
			dy_s1  <= sdiff(in_item.point_y, in_item.start_y);
			qx_s1  <= sdiff(in_item.point_x, in_item.end_x);
			qy_s1  <= sdiff(in_item.point_y, in_item.end_y);
			seg_s1 <= in_item.segment_mode;
		end
	end

	// stage 2: products
	logic signed [PW-1:0] vvx_s2, vvy_s2, dtx_s2, dty_s2, cra_s2, crb_s2;
	logic signed [PW-1:0] ssx_s2, ssy_s2, eex_s2, eey_s2;
	logic                 seg_s2, valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vvx_s2 <= vx_s1 * vx_s1;
			vvy_s2 <= vy_s1 * vy_s1;
			dtx_s2 <= dx_s1 * vx_s1;
			dty_s2 <= dy_s1 * vy_s1;
			cra_s2 <= vx_s1 * dy_s1;
			crb_s2 <= vy_s1 * dx_s1;
			ssx_s2 <= dx_s1 * dx_s1;
			ssy_s2 <= dy_s1 * dy_s1;
			eex_s2 <= qx_s1 * qx_s1;
			eey_s2 <= qy_s1 * qy_s1;
			seg_s2 <= seg_s1;
		end
	end

	// stage 3: sums
	logic signed [SW-1:0] len2_s3, dot_s3, cross_s3, ns_s3, ne_s3;
	logic                 seg_s3, valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len2_s3  <= SW'(vvx_s2) + SW'(vvy_s2);
			dot_s3   <= SW'(dtx_s2) + SW'(dty_s2);
			cross_s3 <= SW'(cra_s2) - SW'(crb_s2);
			ns_s3    <= SW'(ssx_s2) + SW'(ssy_s2);
			ne_s3    <= SW'(eex_s2) + SW'(eey_s2);
			seg_s3   <= seg_s2;
		end
	end

	// stage 4: case select, split square of |cross|
	logic            degen_c, use_div_c, near_s_c, near_e_c;
	logic [SW-1:0]   cabs_c;
	logic [CMAG-1:0] cm_c;
	logic [H-1:0]    clo_c;
	logic [HIW-1:0]  chi_c;
	logic [LW-1:0]   n_c;

	always_comb begin
		degen_c   = (len2_s3 == '0);
		near_s_c  = seg_s3 && (dot_s3 <= $signed(SW'(0)));
		near_e_c  = seg_s3 && (dot_s3 >= len2_s3);
		use_div_c = !degen_c && !near_s_c && !near_e_c;
		cabs_c    = cross_s3[SW-1] ? SW'(-cross_s3) : SW'(cross_s3);
		cm_c      = cabs_c[CMAG-1:0];
		clo_c     = cm_c[H-1:0];
		chi_c     = cm_c[CMAG-1:H];
		if (!degen_c && !near_s_c && near_e_c) begin
			n_c = ne_s3[LW-1:0];
		end else begin
			n_c = ns_s3[LW-1:0];
		end
	end

	logic [2*H-1:0]   ll_s4;
	logic [H+HIW-1:0] hl_s4;
	logic [2*HIW-1:0] hh_s4;
	logic [LW-1:0]    n_s4, len2_s4;
	logic             use_div_s4;
	ptsd_ctl_t        ctl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s4.valid <= valid_s3;
			ctl_s4.degen <= degen_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ll_s4      <= clo_c * clo_c;
			hl_s4      <= chi_c * clo_c;
			hh_s4      <= chi_c * chi_c;
			n_s4       <= n_c;
			len2_s4    <= len2_s3[LW-1:0];
			use_div_s4 <= use_div_c;
		end
	end

	// stage 5: numerator and divisor
	logic [2*CMAG-1:0] csq_c;

	always_comb begin
		csq_c = ((2*CMAG)'(hh_s4) << (2 * H)) + ((2*CMAG)'(hl_s4) << (H + 1))
			+ (2*CMAG)'(ll_s4);
	end

	ptsd_ctl_t     ctl_s5;
	logic [NW-1:0] num_s5;
	logic [LW-1:0] den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
		end else if (adv) begin
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (use_div_s4) begin
				num_s5 <= NW'(csq_c) << (2 * FRAC_BITS);
				den_s5 <= len2_s4;
			end else begin
				num_s5 <= NW'(n_s4) << (2 * FRAC_BITS);
				den_s5 <= LW'(1);
			end
		end
	end

	assign ctl = ctl_s5;
	assign num = num_s5;
	assign den = den_s5;

endmodule

// ===== sv/ptsd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module ptsd_div import ptsd_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  ptsd_ctl_t                     in_ctl,
	input  logic [2*CMAG+2*FRAC_BITS-1:0] num,
	input  logic [LW-1:0]                 den,
	output ptsd_ctl_t                     out_ctl,
	output logic [2*CW+1+2*FRAC_BITS-1:0] quo
);

	localparam int NW = 2 * CMAG + 2 * FRAC_BITS;
	localparam int QW = 2 * CW + 1 + 2 * FRAC_BITS;

	// quotient is known to fit QW bits, so the top bits start as the remainder
	logic [LW-1:0] rem_s [0:QW];
	logic [QW-1:0] nq_s  [0:QW];
	logic [LW-1:0] den_s [0:QW];
	ptsd_ctl_t     ctl_s [0:QW];

	assign rem_s[0] = num[NW-1:QW];
	assign nq_s[0]  = num[QW-1:0];
	assign den_s[0] = den;
	assign ctl_s[0] = in_ctl;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [LW:0]   r2, diff;
		logic          ge;

		always_comb begin
			r2   = {rem_s[i], nq_s[i][QW-1]};
			diff = r2 - {1'b0, den_s[i]};
			ge   = (r2 >= {1'b0, den_s[i]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else if (adv) begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1] <= ge ? diff[LW-1:0] : r2[LW-1:0];
				nq_s[i+1]  <= {nq_s[i][QW-2:0], ge};
				den_s[i+1] <= den_s[i];
			end
		end
	end

	assign out_ctl = ctl_s[QW];
	assign quo     = nq_s[QW];

endmodule

// ===== sv/ptsd_sqrt.sv =====
// Pipelined saturating integer square root, one root bit per stage.
module ptsd_sqrt import ptsd_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  ptsd_ctl_t                     in_ctl,
	input  logic [2*CW+1+2*FRAC_BITS-1:0] val,
	output ptsd_ctl_t                     out_ctl,
	output logic [OUT_BITS-1:0]           root
);

	localparam int QW = 2 * CW + 1 + 2 * FRAC_BITS;
	localparam int RW = OUT_BITS + 1;

	logic [QW+SQW-1:0] vx;
	logic              sat0;

	assign vx   = (QW+SQW)'(val);
	assign sat0 = |vx[QW+SQW-1:SQW];

	logic [RW-1:0]       rem_s  [0:OUT_BITS];
	logic [OUT_BITS-1:0] rt_s   [0:OUT_BITS];
	logic [SQW-1:0]      rad_s  [0:OUT_BITS];
	logic                sat_s  [0:OUT_BITS];
	ptsd_ctl_t           ctl_s  [0:OUT_BITS];

	assign rem_s[0] = '0;
	assign rt_s[0]  = '0;
	assign rad_s[0] = vx[SQW-1:0];
	assign sat_s[0] = sat0;
	assign ctl_s[0] = in_ctl;

	for (genvar i = 0; i < OUT_BITS; i++) begin : g_stage
		logic [RW+1:0] cur, trial, diff;
		logic          ge;

		always_comb begin
			cur   = {rem_s[i], rad_s[i][SQW-1:SQW-2]};
			trial = (RW+2)'({rt_s[i], 2'b01});
			diff  = cur - trial;
			ge    = (cur >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else if (adv) begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1] <= ge ? diff[RW-1:0] : cur[RW-1:0];
				rt_s[i+1]  <= {rt_s[i][OUT_BITS-2:0], ge};
				rad_s[i+1] <= {rad_s[i][SQW-3:0], 2'b00};
				sat_s[i+1] <= sat_s[i];
			end
		end
	end

	assign out_ctl = ctl_s[OUT_BITS];
	assign root    = sat_s[OUT_BITS] ? {OUT_BITS{1'b1}} : rt_s[OUT_BITS];

endmodule
